// ===== sv/ssq_pkg.sv =====
// ----------------------------------------------------------------------------
// ssq_pkg
// Shared types and codes for the sorted sleep timer queue.
// ----------------------------------------------------------------------------
`default_nettype none

package ssq_pkg;

   localparam int ClockW     = 64;
   localparam int IdFieldW   = 8;
   localparam int IdMaxW     = 16;
   localparam int KindW      = 2;
   localparam int ReqDataW   = 136;
   localparam int RspDataW   = 72;

   localparam logic REQ_SLEEP = 1'b0;
   localparam logic REQ_WAKE  = 1'b1;

   localparam logic [KindW-1:0] KIND_SLEEP_OK    = 2'd0;
   localparam logic [KindW-1:0] KIND_FULL        = 2'd1;
   localparam logic [KindW-1:0] KIND_WOKEN       = 2'd2;
   localparam logic [KindW-1:0] KIND_CHECK_DONE  = 2'd3;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_INS_STEP,
      ST_INS_CMP,
      ST_WAKE_STEP,
      ST_WAKE_CMP,
      ST_EMIT
   } state_type;

endpackage

`default_nettype wire

// ===== sv/ssq_mem.sv =====
// ----------------------------------------------------------------------------
// ssq_mem
// Entry store, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module ssq_mem #(
   parameter int DEPTH = 16,
   parameter int WIDTH = 72,
   parameter int ADDR_W = 4
) (
   input  wire logic              clock,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data_ff,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data
);

   logic [WIDTH-1:0] entry_mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= entry_mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

// ===== sv/ssq_ctrl.sv =====
// ----------------------------------------------------------------------------
// ssq_ctrl
// Queue sequencer: sorted insert by tail shifting, release from the head,
// result register.
// ----------------------------------------------------------------------------
`default_nettype none

module ssq_ctrl #(
   parameter int QUEUE_DEPTH  = 16,
   parameter int TASK_ID_BITS = 8,
   parameter int IDX_W        = 4,
   parameter int CNT_W        = 5,
   parameter int ENT_W        = 72
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output logic                                req_ready,
   input  wire logic                           req_kind,
   input  wire logic [ssq_pkg::ClockW-1:0]     req_now,
   input  wire logic [ssq_pkg::IdFieldW-1:0]   req_task,
   input  wire logic [ssq_pkg::ClockW-1:0]     req_delay,
   output logic                                rsp_valid_ff,
   input  wire logic                           rsp_ready,
   output logic      [ssq_pkg::KindW-1:0]      rsp_kind_ff,
   output logic      [ssq_pkg::IdFieldW-1:0]   rsp_task_ff,
   output logic      [ssq_pkg::ClockW-1:0]     rsp_ttn_ff,
   output logic                                rsp_last_ff,
   output logic                                mem_rd_en,
   output logic      [IDX_W-1:0]               mem_rd_addr,
   input  wire logic [ENT_W-1:0]               mem_rd_data,
   output logic                                mem_wr_en,
   output logic      [IDX_W-1:0]               mem_wr_addr,
   output logic      [ENT_W-1:0]               mem_wr_data
);

   localparam int CW = ssq_pkg::ClockW;

   ssq_pkg::state_type state_ff, state_in;

   logic [IDX_W-1:0]            head_ff, head_in;
   logic [CNT_W-1:0]            count_ff, count_in;
   logic [CNT_W-1:0]            cur_ff, cur_in;
   logic [CW-1:0]               wake_ff, wake_in;
   logic [CW-1:0]               now_ff, now_in;
   logic [TASK_ID_BITS-1:0]     task_ff, task_in;
   logic [ssq_pkg::KindW-1:0]   kind_ff, kind_in;
   logic [CW-1:0]               ttn_ff, ttn_in;

   logic                        rsp_valid_in;
   logic [ssq_pkg::KindW-1:0]   rsp_kind_in;
   logic [ssq_pkg::IdFieldW-1:0] rsp_task_in;
   logic [CW-1:0]               rsp_ttn_in;
   logic                        rsp_last_in;

   logic                        out_free;
   logic [CW-1:0]               rd_wake;
   logic [TASK_ID_BITS-1:0]     rd_task;

   // logical position to memory address, wrapping at the queue depth
   function automatic logic [IDX_W-1:0] phys(input logic [IDX_W-1:0] h,
                                             input logic [CNT_W-1:0] j);
      logic [CNT_W:0] s;
      s = (CNT_W+1)'(h) + (CNT_W+1)'(j);
      if (s >= (CNT_W+1)'(QUEUE_DEPTH)) begin
         s = s - (CNT_W+1)'(QUEUE_DEPTH);
      end
      return IDX_W'(s);
   endfunction

   assign rd_wake = mem_rd_data[CW-1:0];
   assign rd_task = mem_rd_data[ENT_W-1:CW];
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ssq_pkg::ST_IDLE);

   always_comb begin
      state_in     = state_ff;
      head_in      = head_ff;
      count_in     = count_ff;
      cur_in       = cur_ff;
      wake_in      = wake_ff;
      now_in       = now_ff;
      task_in      = task_ff;
      kind_in      = kind_ff;
      ttn_in       = ttn_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_kind_in  = rsp_kind_ff;
      rsp_task_in  = rsp_task_ff;
      rsp_ttn_in   = rsp_ttn_ff;
      rsp_last_in  = rsp_last_ff;
      mem_rd_en    = 1'b0;
      mem_rd_addr  = phys(head_ff, cur_ff - CNT_W'(1));
      mem_wr_en    = 1'b0;
      mem_wr_addr  = phys(head_ff, cur_ff);
      mem_wr_data  = {task_ff, wake_ff};

      case (state_ff)
         ssq_pkg::ST_IDLE: begin
            if (req_valid) begin
               now_in  = req_now;
               wake_in = req_now + req_delay + CW'(1);
               task_in = TASK_ID_BITS'(ssq_pkg::IdMaxW'(req_task));
               cur_in  = count_ff;
               ttn_in  = '0;
               if (req_kind == ssq_pkg::REQ_WAKE) begin
                  state_in = ssq_pkg::ST_WAKE_STEP;
               end else if (count_ff == CNT_W'(QUEUE_DEPTH)) begin
                  kind_in  = ssq_pkg::KIND_FULL;
                  state_in = ssq_pkg::ST_EMIT;
               end else begin
                  state_in = ssq_pkg::ST_INS_STEP;
               end
            end
         end
         ssq_pkg::ST_INS_STEP: begin
            if (cur_ff == '0) begin
               mem_wr_en = 1'b1;
               count_in  = count_ff + CNT_W'(1);
               kind_in   = ssq_pkg::KIND_SLEEP_OK;
               state_in  = ssq_pkg::ST_EMIT;
            end else begin
               mem_rd_en = 1'b1;
               state_in  = ssq_pkg::ST_INS_CMP;
            end
         end
         ssq_pkg::ST_INS_CMP: begin
            mem_wr_en = 1'b1;
            if (rd_wake > wake_ff) begin
               // later entry moves one place toward the tail
               mem_wr_data = mem_rd_data;
               cur_in      = cur_ff - CNT_W'(1);
               state_in    = ssq_pkg::ST_INS_STEP;
            end else begin
               count_in = count_ff + CNT_W'(1);
               kind_in  = ssq_pkg::KIND_SLEEP_OK;
               state_in = ssq_pkg::ST_EMIT;
            end
         end
         ssq_pkg::ST_WAKE_STEP: begin
            if (count_ff == '0) begin
               kind_in  = ssq_pkg::KIND_CHECK_DONE;
               ttn_in   = '1;
               state_in = ssq_pkg::ST_EMIT;
            end else begin
               mem_rd_en   = 1'b1;
               mem_rd_addr = head_ff;
               state_in    = ssq_pkg::ST_WAKE_CMP;
            end
         end
         ssq_pkg::ST_WAKE_CMP: begin
            if (now_ff >= rd_wake) begin
               if (out_free) begin
                  rsp_valid_in = 1'b1;
                  rsp_kind_in  = ssq_pkg::KIND_WOKEN;
                  rsp_task_in  = ssq_pkg::IdFieldW'(ssq_pkg::IdMaxW'(rd_task));
                  rsp_ttn_in   = '0;
                  rsp_last_in  = 1'b0;
                  head_in      = (head_ff == IDX_W'(QUEUE_DEPTH - 1)) ? '0
                                                                       : head_ff + IDX_W'(1);
                  count_in     = count_ff - CNT_W'(1);
                  state_in     = ssq_pkg::ST_WAKE_STEP;
               end
            end else begin
               kind_in  = ssq_pkg::KIND_CHECK_DONE;
               ttn_in   = rd_wake - now_ff;
               state_in = ssq_pkg::ST_EMIT;
            end
         end
         ssq_pkg::ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = kind_ff;
               rsp_task_in  = '0;
               rsp_ttn_in   = ttn_ff;
               rsp_last_in  = 1'b1;
               state_in     = ssq_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = ssq_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ssq_pkg::ST_IDLE;
         head_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff      <= cur_in;
      wake_ff     <= wake_in;
      now_ff      <= now_in;
      task_ff     <= task_in;
      kind_ff     <= kind_in;
      ttn_ff      <= ttn_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_task_ff <= rsp_task_in;
      rsp_ttn_ff  <= rsp_ttn_in;
      rsp_last_ff <= rsp_last_in;
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(QUEUE_DEPTH))
      else $error("entry count beyond queue depth");

   a_insert_room: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ssq_pkg::ST_INS_STEP || state_ff == ssq_pkg::ST_INS_CMP)
      |-> (cur_ff <= count_ff && count_ff < CNT_W'(QUEUE_DEPTH)))
      else $error("insert cursor out of range or queue full");

   a_port_clash: assert property (@(posedge clock) disable iff (reset)
      !(mem_rd_en && mem_wr_en))
      else $error("read and write in the same cycle");

   a_release_pops: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ssq_pkg::ST_WAKE_CMP && out_free && now_ff >= rd_wake)
      |=> (count_ff == $past(count_ff) - CNT_W'(1)))
      else $error("released task not removed from queue");

endmodule

`default_nettype wire

// ===== sv/sorted_sleep_timer_queue.sv =====
// ----------------------------------------------------------------------------
// sorted_sleep_timer_queue
// Sleeping tasks kept sorted by wake time in a circular entry memory.
//
//   channel | direction | tdata                               | tuser  | tlast
//   req_    | in        | now_clock, task_id, delay_clocks    | type   | -
//   rsp_    | out       | woken_task, time_to_next            | kind   | last
//
// sleep request: from the tail, each later entry is read and shifted one place toward
// the tail until the new entry's slot is found; a full queue answers with no insert.
// wake check: due head entries are read and released, then a closing result follows.
// reset clears state, head, count and output valid only; entry memory needs no clearing.
// a new request is taken once the closing result sits in the output register;
// a stalled result channel holds the sequencer before each result.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_sleep_timer_queue #(
   parameter int QUEUE_DEPTH  = 16,
   parameter int TASK_ID_BITS = 8
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   // now_clock [63:0], task_id [71:64], delay_clocks [135:72]
   input  wire logic [ssq_pkg::ReqDataW-1:0]    req_tdata,
   // req_type [0]
   input  wire logic [0:0]                      req_tuser,
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   // woken_task [7:0], time_to_next [71:8]
   output logic      [ssq_pkg::RspDataW-1:0]    rsp_tdata,
   // result_kind [1:0]
   output logic      [ssq_pkg::KindW-1:0]       rsp_tuser,
   output logic                                 rsp_tlast
);

   localparam int IdxW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CntW = $clog2(QUEUE_DEPTH + 1);
   localparam int EntW = ssq_pkg::ClockW + TASK_ID_BITS;
   localparam int CW   = ssq_pkg::ClockW;
   localparam int IW   = ssq_pkg::IdFieldW;

   logic                 mem_rd_en;
   logic [IdxW-1:0]      mem_rd_addr;
   logic [EntW-1:0]      mem_rd_data;
   logic                 mem_wr_en;
   logic [IdxW-1:0]      mem_wr_addr;
   logic [EntW-1:0]      mem_wr_data;
   logic [IW-1:0]        rsp_task;
   logic [CW-1:0]        rsp_ttn;

   ssq_ctrl #(
      .QUEUE_DEPTH  (QUEUE_DEPTH),
      .TASK_ID_BITS (TASK_ID_BITS),
      .IDX_W        (IdxW),
      .CNT_W        (CntW),
      .ENT_W        (EntW)
   ) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_tvalid),
      .req_ready    (req_tready),
      .req_kind     (req_tuser[0]),
      .req_now      (req_tdata[CW-1:0]),
      .req_task     (req_tdata[CW+IW-1:CW]),
      .req_delay    (req_tdata[2*CW+IW-1:CW+IW]),
      .rsp_valid_ff (rsp_tvalid),
      .rsp_ready    (rsp_tready),
      .rsp_kind_ff  (rsp_tuser),
      .rsp_task_ff  (rsp_task),
      .rsp_ttn_ff   (rsp_ttn),
      .rsp_last_ff  (rsp_tlast),
      .mem_rd_en    (mem_rd_en),
      .mem_rd_addr  (mem_rd_addr),
      .mem_rd_data  (mem_rd_data),
      .mem_wr_en    (mem_wr_en),
      .mem_wr_addr  (mem_wr_addr),
      .mem_wr_data  (mem_wr_data)
   );

   ssq_mem #(
      .DEPTH  (QUEUE_DEPTH),
      .WIDTH  (EntW),
      .ADDR_W (IdxW)
   ) u_mem (
      .clock      (clock),
      .rd_en      (mem_rd_en),
      .rd_addr    (mem_rd_addr),
      .rd_data_ff (mem_rd_data),
      .wr_en      (mem_wr_en),
      .wr_addr    (mem_wr_addr),
      .wr_data    (mem_wr_data)
   );

   assign rsp_tdata = {rsp_ttn, rsp_task};

endmodule

`default_nettype wire

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Sends sleep requests and wake checks into the sorted sleep timer queue with
// random gaps on both channels and one long response stall. A scoreboard
// class keeps its own sorted copy of the queue, predicts every response and
// compares each one field by field as it is accepted.
// ----------------------------------------------------------------------------
module testbench;

   localparam int ClockW      = ssq_pkg::ClockW;
   localparam int IdFieldW    = ssq_pkg::IdFieldW;
   localparam int KindW       = ssq_pkg::KindW;
   localparam int ReqDataW    = ssq_pkg::ReqDataW;
   localparam int RspDataW    = ssq_pkg::RspDataW;
   localparam int QueueDepth  = 16;
   localparam int IdBits      = 8;
   localparam int CycleLimit  = 400000;
   localparam int RandomItems = 195;
   localparam int CalmItems   = 30;
   localparam int HoldAfter   = 40;
   localparam int HoldCycles  = 400;
   localparam int DrainCycles = 60;

   typedef struct packed {
      logic [KindW-1:0]    kind;
      logic [IdFieldW-1:0] woken;
      logic [ClockW-1:0]   ttn;
      logic                last;
   } rsp_fields_type;

   class timer_queue_scoreboard;
      logic [ClockW-1:0]   wake_at [QueueDepth];
      logic [IdFieldW-1:0] task_at [QueueDepth];
      int unsigned         count;
      rsp_fields_type      owed_results [$];
      int                  failures;

      function new();
         count    = 0;
         failures = 0;
      endfunction

      function void owe(logic [KindW-1:0] kind, logic [IdFieldW-1:0] woken,
                        logic [ClockW-1:0] ttn, logic last);
         rsp_fields_type r;
         r.kind  = kind;
         r.woken = woken;
         r.ttn   = ttn;
         r.last  = last;
         owed_results.push_back(r);
      endfunction

      function void note_request(logic is_wake, logic [ClockW-1:0] now_clock,
                                 logic [IdFieldW-1:0] task_id,
                                 logic [ClockW-1:0] delay);
         logic [ClockW-1:0] wake;
         int unsigned       pos;
         int unsigned       released;
         if (is_wake == ssq_pkg::REQ_SLEEP) begin
            wake = now_clock + delay + 64'd1;
            if (count >= QueueDepth) begin
               owe(ssq_pkg::KIND_FULL, '0, '0, 1'b1);
            end else begin
               pos = 0;
               while (pos < count && wake_at[pos] <= wake) pos++;
               for (int i = count; i > int'(pos); i--) begin
                  wake_at[i] = wake_at[i-1];
                  task_at[i] = task_at[i-1];
               end
               wake_at[pos] = wake;
               task_at[pos] = task_id;
               count++;
               owe(ssq_pkg::KIND_SLEEP_OK, '0, '0, 1'b1);
            end
         end else begin
            released = 0;
            while (released < count && now_clock >= wake_at[released]) begin
               owe(ssq_pkg::KIND_WOKEN, task_at[released], '0, 1'b0);
               released++;
            end
            for (int i = 0; i + released < count; i++) begin
               wake_at[i] = wake_at[i+released];
               task_at[i] = task_at[i+released];
            end
            count -= released;
            if (count > 0) begin
               owe(ssq_pkg::KIND_CHECK_DONE, '0, wake_at[0] - now_clock, 1'b1);
            end else begin
               owe(ssq_pkg::KIND_CHECK_DONE, '0, '1, 1'b1);
            end
         end
      endfunction

      function void check_result(rsp_fields_type got);
         rsp_fields_type want;
         if (owed_results.size() == 0) begin
            $display("%0t: expected none, actual kind %0d task %0d ttn %h last %0d",
                     $time, got.kind, got.woken, got.ttn, got.last);
            failures++;
            return;
         end
         want = owed_results.pop_front();
         if (got.kind !== want.kind) begin
            $display("%0t: result_kind expected %0d actual %0d", $time, want.kind, got.kind);
            failures++;
         end
         if (got.woken !== want.woken) begin
            $display("%0t: woken_task expected %0d actual %0d", $time, want.woken, got.woken);
            failures++;
         end
         if (got.ttn !== want.ttn) begin
            $display("%0t: time_to_next expected %h actual %h", $time, want.ttn, got.ttn);
            failures++;
         end
         if (got.last !== want.last) begin
            $display("%0t: last_result expected %0d actual %0d", $time, want.last, got.last);
            failures++;
         end
      endfunction
   endclass

   logic                clock      = 1'b0;
   logic                reset      = 1'b1;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [ReqDataW-1:0] req_tdata  = '0;
   logic [0:0]          req_tuser  = '0;
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [RspDataW-1:0] rsp_tdata;
   logic [KindW-1:0]    rsp_tuser;
   logic                rsp_tlast;

   logic                  calm = 1'b0;
   int                    results_seen = 0;
   int                    cycle_count = 0;
   timer_queue_scoreboard board = new();

   sorted_sleep_timer_queue #(
      .QUEUE_DEPTH  (QueueDepth),
      .TASK_ID_BITS (IdBits)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   initial begin
      while (cycle_count < CycleLimit) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   function automatic logic [ClockW-1:0] rand64();
      return {$urandom, $urandom};
   endfunction

   task automatic send_request(logic is_wake, logic [ClockW-1:0] now_clock,
                               logic [IdFieldW-1:0] task_id,
                               logic [ClockW-1:0] delay);
      if (!calm && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {delay, task_id, now_clock};
      req_tuser  <= is_wake;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      board.note_request(is_wake, now_clock, task_id, delay);
   endtask

   // response side: random stalls plus one long hold-off
   initial begin
      int             idle_left;
      int             hold_left;
      bit             held;
      rsp_fields_type got;
      idle_left = 0;
      hold_left = 0;
      held      = 1'b0;
      while (reset) @(posedge clock);
      forever begin
         @(posedge clock);
         if (rsp_tvalid && rsp_tready) begin
            got.kind  = rsp_tuser;
            got.woken = rsp_tdata[IdFieldW-1:0];
            got.ttn   = rsp_tdata[IdFieldW +: ClockW];
            got.last  = rsp_tlast;
            board.check_result(got);
            results_seen++;
         end
         if (!held && results_seen >= HoldAfter) begin
            held      = 1'b1;
            hold_left = HoldCycles;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (idle_left > 0) begin
            idle_left--;
            rsp_tready <= 1'b0;
         end else if (!calm && $urandom_range(0, 4) == 0) begin
            idle_left = $urandom_range(1, 12) - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   initial begin
      logic [ClockW-1:0] sim_clock;
      int                sent;
      int                mode;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // empty queue, equal wake times, wrap through now and through delay
      send_request(ssq_pkg::REQ_WAKE, 64'd0, 8'h00, 64'd0);
      send_request(ssq_pkg::REQ_SLEEP, 64'd0, 8'h00, 64'd0);
      send_request(ssq_pkg::REQ_SLEEP, 64'd0, 8'hff, 64'd0);
      send_request(ssq_pkg::REQ_SLEEP, '1, 8'h5a, 64'd0);
      send_request(ssq_pkg::REQ_SLEEP, 64'd5, 8'ha5, '1);
      send_request(ssq_pkg::REQ_WAKE, 64'd0, 8'h00, 64'd0);
      send_request(ssq_pkg::REQ_WAKE, '1, 8'hff, '1);
      // fill, reject when full, then release everything in one check
      for (int i = 0; i < QueueDepth; i++) begin
         send_request(ssq_pkg::REQ_SLEEP, 64'd1000, 8'(i * 17),
                      64'($urandom_range(0, 7)));
      end
      send_request(ssq_pkg::REQ_SLEEP, 64'd1000, 8'haa, 64'd3);
      send_request(ssq_pkg::REQ_WAKE, '1, 8'h00, 64'd0);

      sim_clock = rand64() >> 2;
      sent = 0;
      while (sent < RandomItems) begin
         if (sent >= RandomItems - CalmItems) calm = 1'b1;
         mode = $urandom_range(0, 19);
         if (mode < 12) begin
            sim_clock += 64'($urandom_range(0, 40));
            if ($urandom_range(0, 2) != 0) begin
               send_request(ssq_pkg::REQ_SLEEP, sim_clock, 8'($urandom),
                            64'($urandom_range(0, 80)));
            end else begin
               send_request(ssq_pkg::REQ_WAKE, sim_clock, 8'($urandom), rand64());
            end
            sent++;
         end else if (mode < 14) begin
            for (int i = 0; i < QueueDepth + 2; i++) begin
               send_request(ssq_pkg::REQ_SLEEP, sim_clock, 8'($urandom),
                            64'($urandom_range(0, 3)));
            end
            sim_clock += 64'd8;
            send_request(ssq_pkg::REQ_WAKE, sim_clock, 8'($urandom), rand64());
            send_request(ssq_pkg::REQ_WAKE, '1, 8'($urandom), rand64());
            sent += QueueDepth + 4;
         end else if (mode < 17) begin
            send_request(1'($urandom_range(0, 1)), rand64(), 8'($urandom), rand64());
            sent++;
         end else begin
            // delay close to all ones lands at or just before now
            send_request(ssq_pkg::REQ_SLEEP, sim_clock, 8'($urandom),
                         '1 - 64'($urandom_range(0, 50)));
            sent++;
         end
      end

      calm = 1'b1;
      req_tvalid <= 1'b0;
      while (board.owed_results.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
      if (board.failures == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
sv/ssq_pkg.sv
sv/ssq_mem.sv
sv/ssq_ctrl.sv
sv/sorted_sleep_timer_queue.sv
dv/testbench.sv
